>>> rtl/tbdmc_pkg.sv
package tbdmc_pkg;

	// Configuration register indexes
	localparam logic REG_DEBOUNCE   = 1'b0;
	localparam logic REG_LONG_PRESS = 1'b1;

	// Reset values of the configuration registers
	localparam logic [15:0] DEBOUNCE_RESET   = 16'd50;
	localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;

	// Events of one debounced button for the tick being processed
	typedef struct packed {
		logic press;     // accepted level went to pressed
		logic freed;     // accepted level went to released
		logic long_hit;  // accepted pressed and held past the long-press time
	} btn_ev_t;

endpackage

>>> rtl/tbdmc_debounce.sv
module tbdmc_debounce #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   raw,
	input  logic [15:0]            debounce_ticks,
	input  logic [15:0]            long_press_ticks,
	output tbdmc_pkg::btn_ev_t     ev
);

	localparam int CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

	logic                   last_raw_q;
	logic                   stable_q;
	logic [TIMER_WIDTH-1:0] elapsed_q;
	logic [TIMER_WIDTH-1:0] elapsed_nxt;
	logic                   accept;
	logic                   change;
	logic                   stable_nxt;

	// Elapsed counter: restart on a raw edge, saturate at the top
	always_comb begin
		if (raw != last_raw_q) begin
			elapsed_nxt = '0;
		end else if (&elapsed_q) begin
			elapsed_nxt = elapsed_q;
		end else begin
			elapsed_nxt = elapsed_q + TIMER_WIDTH'(1);
		end
	end

	// Acceptance and events
	always_comb begin
		accept      = CW'(elapsed_nxt) > CW'(debounce_ticks);
		change      = raw != stable_q;
		stable_nxt  = (accept && change) ? raw : stable_q;
		ev.press    = accept && change && !raw;
		ev.freed    = accept && change && raw;
		ev.long_hit = accept && !stable_nxt && (CW'(elapsed_nxt) > CW'(long_press_ticks));
	end

	// State advances only when the tick is committed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q <= 1'b1;
			stable_q   <= 1'b0;
			elapsed_q  <= '0;
		end else if (en) begin
			last_raw_q <= raw;
			stable_q   <= stable_nxt;
			elapsed_q  <= elapsed_nxt;
		end
	end

endmodule

>>> rtl/two_button_debounce_menu_control.sv
// Two-button menu control. Each input item is one millisecond tick with the raw
// active-low levels of the menu and up/down buttons and the display-off flag;
// each tick yields exactly one result item. Both buttons are debounced by
// saturating elapsed counters (TIMER_WIDTH bits) and a level is accepted once
// stable for more than debounce_ticks. Releasing the menu button toggles menu
// mode or requests the display on, unless a long press or a chorded down-step
// happened; in menu mode with display on, pressing up/down steps the threshold
// (down while menu is held), else requests display on; a long up/down hold
// repeats a step every tick. One item per clock, unless out_stall holds it,
// passes an input register, compare and flag logic and the result register.
// Accepted levels start pressed; a line held from reset gives no press event.
// The user must write configuration only while the block is idle; unenforced.
module two_button_debounce_menu_control #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	// tick channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              menu_raw,
	input  logic              updown_raw,
	input  logic              display_off,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic              in_menu,
	output logic              enter_menu,
	output logic              exit_and_save,
	output logic              turn_on_display,
	output logic signed [2:0] threshold_step,
	// configuration
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data
);

	logic [15:0] debounce_ticks_q;
	logic [15:0] long_press_ticks_q;

	logic valid_s1;
	logic menu_raw_s1;
	logic updown_raw_s1;
	logic display_off_s1;

	logic advance;
	logic commit;

	logic menu_mode_q, menu_held_q, menu_long_q, down_used_q, updown_long_q;
	logic mode_n, held_n, mlong_n, down_n, ulong_n;
	logic enter_n, leave_n, turn_on_n;
	logic signed [2:0] step_n;

	tbdmc_pkg::btn_ev_t menu_ev;
	tbdmc_pkg::btn_ev_t updown_ev;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q   <= tbdmc_pkg::DEBOUNCE_RESET;
			long_press_ticks_q <= tbdmc_pkg::LONG_PRESS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tbdmc_pkg::REG_DEBOUNCE:   debounce_ticks_q   <= cfg_data;
				tbdmc_pkg::REG_LONG_PRESS: long_press_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: input stage moves on when the result register is free or draining
	assign advance  = !out_valid || !out_stall;
	assign commit   = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			menu_raw_s1    <= menu_raw;
			updown_raw_s1  <= updown_raw;
			display_off_s1 <= display_off;
		end
	end

	// Debouncers
	tbdmc_debounce #(.TIMER_WIDTH(TIMER_WIDTH)) u_menu_deb (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (commit),
		.raw              (menu_raw_s1),
		.debounce_ticks   (debounce_ticks_q),
		.long_press_ticks (long_press_ticks_q),
		.ev               (menu_ev)
	);

	tbdmc_debounce #(.TIMER_WIDTH(TIMER_WIDTH)) u_updown_deb (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (commit),
		.raw              (updown_raw_s1),
		.debounce_ticks   (debounce_ticks_q),
		.long_press_ticks (long_press_ticks_q),
		.ev               (updown_ev)
	);

	// Menu button first, then up/down sees the updated mode and hold flag
	always_comb begin
		mode_n    = menu_mode_q;
		held_n    = menu_held_q;
		mlong_n   = menu_long_q;
		down_n    = down_used_q;
		ulong_n   = updown_long_q;
		enter_n   = 1'b0;
		leave_n   = 1'b0;
		turn_on_n = 1'b0;
		step_n    = 3'sd0;

		if (menu_ev.press) begin
			held_n = 1'b1;
		end
		if (menu_ev.freed) begin
			if (menu_held_q && !menu_long_q && !down_used_q) begin
				if (!display_off_s1) begin
					mode_n  = !menu_mode_q;
					enter_n = !menu_mode_q;
					leave_n = menu_mode_q;
				end else begin
					turn_on_n = 1'b1;
				end
			end
			mlong_n = 1'b0;
			down_n  = 1'b0;
			held_n  = 1'b0;
		end
		if (menu_ev.long_hit && !down_n) begin
			mlong_n = 1'b1;
		end

		if (updown_ev.press) begin
			if (!display_off_s1 && mode_n) begin
				if (held_n) begin
					down_n = 1'b1;
					step_n = -3'sd1;
				end else begin
					step_n = 3'sd1;
				end
			end else begin
				turn_on_n = 1'b1;
			end
		end
		if (updown_ev.freed) begin
			ulong_n = 1'b0;
		end
		// auto-repeat, independent of display and mode
		if (updown_ev.long_hit) begin
			ulong_n = 1'b1;
			step_n  = held_n ? (step_n - 3'sd1) : (step_n + 3'sd1);
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			menu_mode_q   <= 1'b0;
			menu_held_q   <= 1'b0;
			menu_long_q   <= 1'b0;
			down_used_q   <= 1'b0;
			updown_long_q <= 1'b0;
		end else if (commit) begin
			menu_mode_q   <= mode_n;
			menu_held_q   <= held_n;
			menu_long_q   <= mlong_n;
			down_used_q   <= down_n;
			updown_long_q <= ulong_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			in_menu         <= mode_n;
			enter_menu      <= enter_n;
			exit_and_save   <= leave_n;
			turn_on_display <= turn_on_n;
			threshold_step  <= step_n;
		end
	end

`ifndef ASSERT_OFF
	// Entering or leaving must agree with the reported mode
	a_enter_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && enter_menu |-> in_menu && !exit_and_save)
		else $error("enter_menu without menu mode");

	a_exit_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && exit_and_save |-> !in_menu)
		else $error("exit_and_save while still in menu mode");

	// A chorded down-step only exists during a menu hold
	a_down_held: assert property (@(posedge clk) disable iff (!arst_n)
		down_used_q |-> menu_held_q)
		else $error("down_used set without menu held");

	// Up/down long-press flag only while its accepted level is pressed
	a_ulong_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		commit && updown_long_q |-> !updown_ev.freed || !ulong_n)
		else $error("updown long flag kept across release");
`endif

endmodule

>>> sim/tb_two_button_debounce_menu_control.sv
module tb_two_button_debounce_menu_control;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 2000;
	localparam int REPORT_MAX  = 10;
	localparam int CNT_MAX     = 16'hFFFF;

	typedef struct packed {
		logic menu_raw;
		logic updown_raw;
		logic display_off;
	} tick_t;

	typedef struct packed {
		logic              in_menu;
		logic              enter_menu;
		logic              exit_and_save;
		logic              turn_on_display;
		logic signed [2:0] threshold_step;
	} menu_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              menu_raw = 1'b1;
	logic              updown_raw = 1'b1;
	logic              display_off = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              in_menu;
	logic              enter_menu;
	logic              exit_and_save;
	logic              turn_on_display;
	logic signed [2:0] threshold_step;
	logic              cfg_we = 1'b0;
	logic              cfg_index = tbdmc_pkg::REG_DEBOUNCE;
	logic [15:0]       cfg_data = '0;

	two_button_debounce_menu_control u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.menu_raw        (menu_raw),
		.updown_raw      (updown_raw),
		.display_off     (display_off),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.in_menu         (in_menu),
		.enter_menu      (enter_menu),
		.exit_and_save   (exit_and_save),
		.turn_on_display (turn_on_display),
		.threshold_step  (threshold_step),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// Ticks waiting to be sent, and results waiting to come back
	tick_t        pending_ticks[$];
	menu_result_t awaited_results[$];

	int fail_count = 0;
	int quiet_cycles = 0;
	int hold_req = 0;
	int hold_seen = 0;

	// Predictor copy of configuration and button state
	logic [15:0] deb_ticks = tbdmc_pkg::DEBOUNCE_RESET;
	logic [15:0] long_ticks = tbdmc_pkg::LONG_PRESS_RESET;
	logic        m_last = 1'b1;
	logic        m_stable = 1'b0;
	logic [15:0] m_elapsed = '0;
	logic        u_last = 1'b1;
	logic        u_stable = 1'b0;
	logic [15:0] u_elapsed = '0;
	logic        menu_mode = 1'b0;
	logic        m_held = 1'b0;
	logic        m_long = 1'b0;
	logic        down_used = 1'b0;
	logic        u_long = 1'b0;

	// Saturating elapsed counter: restart on a raw change
	function automatic logic [15:0] count_stable(logic [15:0] cnt, logic raw, logic last);
		if (raw != last)
			return '0;
		if (cnt == CNT_MAX)
			return cnt;
		return cnt + 16'd1;
	endfunction

	// One millisecond tick: menu button first, then up/down
	function automatic menu_result_t step_controls(tick_t t);
		menu_result_t r;
		int           step;
		logic         entered;
		logic         left;
		logic         turn_on;
		step = 0;
		entered = 1'b0;
		left = 1'b0;
		turn_on = 1'b0;

		m_elapsed = count_stable(m_elapsed, t.menu_raw, m_last);
		if (m_elapsed > deb_ticks) begin
			if (t.menu_raw != m_stable) begin
				m_stable = t.menu_raw;
				if (!m_stable) begin
					m_held = 1'b1;
				end else begin
					if (m_held && !m_long && !down_used) begin
						if (!t.display_off) begin
							if (!menu_mode) begin
								menu_mode = 1'b1;
								entered = 1'b1;
							end else begin
								menu_mode = 1'b0;
								left = 1'b1;
							end
						end else begin
							turn_on = 1'b1;
						end
					end
					m_long = 1'b0;
					down_used = 1'b0;
					m_held = 1'b0;
				end
			end
			if (!m_stable && m_elapsed > long_ticks && !m_long && !down_used)
				m_long = 1'b1;
		end
		m_last = t.menu_raw;

		u_elapsed = count_stable(u_elapsed, t.updown_raw, u_last);
		if (u_elapsed > deb_ticks) begin
			if (t.updown_raw != u_stable) begin
				u_stable = t.updown_raw;
				if (!u_stable) begin
					if (!t.display_off && menu_mode) begin
						if (m_held) begin
							down_used = 1'b1;
							step -= 1;
						end else begin
							step += 1;
						end
					end else begin
						turn_on = 1'b1;
					end
				end else begin
					u_long = 1'b0;
				end
			end
			// auto-repeat while held past the long-press time
			if (!u_stable && u_elapsed > long_ticks) begin
				u_long = 1'b1;
				if (m_held)
					step -= 1;
				else
					step += 1;
			end
		end
		u_last = t.updown_raw;

		r.in_menu = menu_mode;
		r.enter_menu = entered;
		r.exit_and_save = left;
		r.turn_on_display = turn_on;
		r.threshold_step = 3'(step);
		return r;
	endfunction

	// Idle length: mostly none or short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Clock and reset
	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Tick driver
	tick_t sent_tick;
	int    send_gap;
	int    send_calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			menu_raw <= 1'b1;
			updown_raw <= 1'b1;
			display_off <= 1'b0;
			send_gap = 0;
			send_calm = 0;
		end else begin
			if (in_valid && !in_stall) begin
				sent_tick = '{menu_raw, updown_raw, display_off};
				awaited_results.push_back(step_controls(sent_tick));
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_ticks.size() != 0) begin
					sent_tick = pending_ticks.pop_front();
					menu_raw <= sent_tick.menu_raw;
					updown_raw <= sent_tick.updown_raw;
					display_off <= sent_tick.display_off;
					in_valid <= 1'b1;
					if (send_calm > 0)
						send_calm--;
					else if ($urandom_range(0, 49) == 0)
						send_calm = $urandom_range(30, 120);
					else
						send_gap = idle_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver stall
	menu_result_t got;
	menu_result_t want;
	int           recv_wait;
	int           recv_calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_wait = 0;
			recv_calm = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{in_menu, enter_menu, exit_and_save, turn_on_display, threshold_step};
				if (awaited_results.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("unexpected item: menu %0b enter %0b exit %0b on %0b step %0d",
							got.in_menu, got.enter_menu, got.exit_and_save,
							got.turn_on_display, got.threshold_step);
				end else begin
					want = awaited_results.pop_front();
					if (got.in_menu !== want.in_menu || got.enter_menu !== want.enter_menu ||
						got.exit_and_save !== want.exit_and_save ||
						got.turn_on_display !== want.turn_on_display ||
						got.threshold_step !== want.threshold_step) begin
						fail_count++;
						if (fail_count <= REPORT_MAX)
							$display("mismatch at %0t: exp %0b %0b %0b %0b %0d got %0b %0b %0b %0b %0d",
								$realtime,
								want.in_menu, want.enter_menu, want.exit_and_save,
								want.turn_on_display, want.threshold_step,
								got.in_menu, got.enter_menu, got.exit_and_save,
								got.turn_on_display, got.threshold_step);
					end
				end
			end
			// long hold-off on request, else random stalls with calm stretches
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				recv_wait = 300;
			end
			if (recv_wait > 0) begin
				recv_wait--;
				out_stall <= 1'b1;
			end else if (recv_calm > 0) begin
				recv_calm--;
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 49) == 0) begin
				recv_calm = $urandom_range(30, 120);
				out_stall <= 1'b0;
			end else begin
				recv_wait = idle_len();
				out_stall <= (recv_wait > 0);
				if (recv_wait > 0)
					recv_wait--;
			end
		end
	end

	// Watchdog on cycles with no handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("tb: failure");
					$finish;
				end
			end
		end
	end

	task automatic queue_hold(logic m, logic u, logic d, int len);
		tick_t t;
		t = '{m, u, d};
		repeat (len) pending_ticks.push_back(t);
	endtask

	// Button segments of at most 48 ticks: mostly aimed past the debounce time,
	// some bounce noise, some aimed past the long-press time
	task automatic queue_random_ticks(int n);
		int    left;
		int    len;
		int    kind;
		tick_t t;
		left = n;
		while (left > 0) begin
			kind = $urandom_range(0, 9);
			if (kind < 2)
				len = $urandom_range(1, 2);
			else if (kind < 8)
				len = int'(deb_ticks) + 1 + $urandom_range(1, 4);
			else
				len = int'(deb_ticks) + int'(long_ticks) + $urandom_range(2, 6);
			if (len > 48)
				len = 48;
			if (len > left)
				len = left;
			t.menu_raw = ($urandom_range(0, 9) >= 4);
			t.updown_raw = ($urandom_range(0, 9) >= 4);
			repeat (len) begin
				t.display_off = ($urandom_range(0, 4) == 0);
				pending_ticks.push_back(t);
			end
			left -= len;
		end
	endtask

	// Wait until every tick is sent and every result has come
	task automatic drain_results();
		while (pending_ticks.size() != 0 || in_valid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == tbdmc_pkg::REG_DEBOUNCE)
			deb_ticks = val;
		else
			long_ticks = val;
	endtask

	task automatic run_phase(logic [15:0] deb, logic [15:0] lng, int n, logic hold_off);
		write_cfg(tbdmc_pkg::REG_DEBOUNCE, deb);
		write_cfg(tbdmc_pkg::REG_LONG_PRESS, lng);
		queue_random_ticks(n);
		if (hold_off)
			hold_req++;
		drain_results();
	endtask

	// Stimulus
	initial begin
		wait (arst_n);
		@(posedge clk);

		// reset settings: lines pressed from reset give no event, release gives no flag
		queue_hold(1'b0, 1'b0, 1'b0, 60);
		queue_hold(1'b1, 1'b1, 1'b0, 55);
		drain_results();

		// directed: enter, step up with repeat, chorded down, exit, display on
		write_cfg(tbdmc_pkg::REG_DEBOUNCE, 16'd0);
		write_cfg(tbdmc_pkg::REG_LONG_PRESS, 16'd2);
		queue_hold(1'b0, 1'b1, 1'b0, 2);
		queue_hold(1'b1, 1'b1, 1'b0, 2);
		queue_hold(1'b1, 1'b0, 1'b0, 4);
		queue_hold(1'b1, 1'b1, 1'b0, 2);
		queue_hold(1'b0, 1'b1, 1'b0, 2);
		queue_hold(1'b0, 1'b0, 1'b0, 2);
		queue_hold(1'b1, 1'b1, 1'b0, 2);
		queue_hold(1'b0, 1'b1, 1'b0, 2);
		queue_hold(1'b1, 1'b1, 1'b0, 2);
		queue_hold(1'b0, 1'b1, 1'b0, 2);
		queue_hold(1'b1, 1'b1, 1'b1, 2);
		queue_hold(1'b0, 1'b1, 1'b0, 4);
		queue_hold(1'b1, 1'b1, 1'b0, 2);
		drain_results();

		// random phases; long-press below debounce gives double steps
		run_phase(16'd0, 16'd0, 100, 1'b0);
		run_phase(16'd1, 16'd4, 100, 1'b1);
		run_phase(16'd3, 16'd1, 100, 1'b0);
		run_phase(16'd2, 16'd8, 100, 1'b0);
		run_phase(16'd0, 16'hFFFF, 100, 1'b0);
		run_phase(16'd4, 16'd2, 100, 1'b0);
		run_phase(16'd1, 16'd12, 100, 1'b0);
		run_phase(16'hFFFF, 16'd0, 20, 1'b0);

		repeat (8) @(posedge clk);
		if (fail_count == 0 && awaited_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
